// File: design/multiply_divide_unit_hi_lo_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multiply/divide unit
// Short forms for clocked assertions that are switched off during reset.
// ----------------------------------------------------------------------------
`ifndef MULTIPLY_DIVIDE_UNIT_HI_LO_TOP_MACROS_SVH
`define MULTIPLY_DIVIDE_UNIT_HI_LO_TOP_MACROS_SVH

// Plain property, checked at every clock edge outside reset.
`define MDU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication.
`define MDU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MDU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/mdu_pkg.sv
// ----------------------------------------------------------------------------
// mdu_pkg
// Types, constants and helpers shared by the multiply/divide unit files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mdu_pkg;

	localparam int DATA_W   = 64;
	localparam int HALF_W   = DATA_W / 2;
	localparam int OP_W     = 4;
	localparam int CNT_W    = $clog2(DATA_W);

	localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
	localparam logic [DATA_W-1:0] ONE      = {{(DATA_W-1){1'b0}}, 1'b1};

	typedef enum logic [OP_W-1:0] {
		OP_MULT   = 4'd0,
		OP_MULTU  = 4'd1,
		OP_DIV    = 4'd2,
		OP_DIVU   = 4'd3,
		OP_DMULT  = 4'd4,
		OP_DMULTU = 4'd5,
		OP_DDIV   = 4'd6,
		OP_DDIVU  = 4'd7,
		OP_MFHI   = 4'd8,
		OP_MFLO   = 4'd9,
		OP_MTHI   = 4'd10,
		OP_MTLO   = 4'd11
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_RUN,
		ST_FIX_A,
		ST_FIX_B,
		ST_FINISH
	} state_t;

	function automatic logic [DATA_W-1:0] sx32(input logic [DATA_W-1:0] v);
		sx32 = {{HALF_W{v[HALF_W-1]}}, v[HALF_W-1:0]};
	endfunction

	function automatic logic [DATA_W-1:0] neg(input logic [DATA_W-1:0] v);
		neg = ~v + ONE;
	endfunction

endpackage

// File: design/mdu_if.sv
// ----------------------------------------------------------------------------
// mdu request and response channels
// Valid/ready channels carrying a request and its result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mdu_req_if;
	import mdu_pkg::*;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     req_type;
	logic [DATA_W-1:0]   rs_value;
	logic [DATA_W-1:0]   rt_value;

	modport source (output valid, output req_type, output rs_value, output rt_value,
		input ready);
	modport sink (input valid, input req_type, input rs_value, input rt_value,
		output ready);
endinterface

interface mdu_rsp_if;
	import mdu_pkg::*;
	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   read_value;
	logic [DATA_W-1:0]   hi_value;
	logic [DATA_W-1:0]   lo_value;

	modport source (output valid, output read_value, output hi_value, output lo_value,
		input ready);
	modport sink (input valid, input read_value, input hi_value, input lo_value,
		output ready);
endinterface

// File: design/multiply_divide_unit_hi_lo_top.sv
// A 64-bit multiply/divide unit holding the HI and LO registers. One request
// is worked on at a time. Multiplies and divides run one bit per cycle through
// a shared shift/add-subtract datapath: after its transfer a request passes
// an operand setup state, the bit iterations, the sign fixups in FIX_A and
// FIX_B and a commit state, and the next request is taken in the cycle after
// the commit. A divide by zero skips the iterations and the fixups and goes
// from setup straight to commit. Moves to and from HI/LO and unused codes go
// straight from idle to commit. The result sits in an output register, so a
// new request may start while the previous result waits; it commits only once
// that result has been taken.
// ----------------------------------------------------------------------------
// multiply_divide_unit_hi_lo_top
// Bit-serial multiply/divide unit with HI/LO registers and valid/ready ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multiply_divide_unit_hi_lo_top_macros.svh"

module multiply_divide_unit_hi_lo_top
	import mdu_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	mdu_req_if.sink   req,
	mdu_rsp_if.source rsp
);

	state_t             state_q, state_d;
	logic [OP_W-1:0]    op_q;
	logic [DATA_W-1:0]  a_q, b_q;
	logic [DATA_W-1:0]  hi_w_q, lo_w_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               neg_q_q, neg_r_q, dz_q;
	logic [DATA_W-1:0]  hi_q, lo_q, rd_q;
	logic               out_valid_q;

	logic               accept, commit;
	logic               is_mul, is_div, sgn_div;
	logic [DATA_W-1:0]  a_fmt, b_fmt;
	logic [DATA_W:0]    mul_sum, div_t, div_d;
	logic [DATA_W-1:0]  new_hi, new_lo, new_rd;

	// Operation classes of the request being worked on
	always_comb begin
		is_mul  = 1'b0;
		is_div  = 1'b0;
		sgn_div = 1'b0;
		case (op_q) inside
			OP_MULT, OP_MULTU, OP_DMULT, OP_DMULTU: is_mul = 1'b1;
			OP_DIV, OP_DDIV: begin
				is_div  = 1'b1;
				sgn_div = 1'b1;
			end
			OP_DIVU, OP_DDIVU: is_div = 1'b1;
			default: ;
		endcase
	end

	// Operands as the operation sees them: 32-bit forms take bits 31..0
	always_comb begin
		case (req.req_type) inside
			OP_MULT, OP_DIV: begin
				a_fmt = sx32(req.rs_value);
				b_fmt = sx32(req.rt_value);
			end
			OP_MULTU, OP_DIVU: begin
				a_fmt = {{HALF_W{1'b0}}, req.rs_value[HALF_W-1:0]};
				b_fmt = {{HALF_W{1'b0}}, req.rt_value[HALF_W-1:0]};
			end
			default: begin
				a_fmt = req.rs_value;
				b_fmt = req.rt_value;
			end
		endcase
	end

	// One iteration step of each kind
	assign mul_sum = {1'b0, hi_w_q} + (lo_w_q[0] ? {1'b0, b_q} : {(DATA_W+1){1'b0}});
	assign div_t   = {hi_w_q, lo_w_q[DATA_W-1]};
	assign div_d   = div_t - {1'b0, b_q};

	// Commit values
	always_comb begin
		new_hi = hi_q;
		new_lo = lo_q;
		new_rd = '0;
		case (op_q) inside
			OP_MULT, OP_MULTU: begin
				new_lo = sx32(lo_w_q);
				new_hi = sx32({{HALF_W{1'b0}}, lo_w_q[DATA_W-1:HALF_W]});
			end
			OP_DMULT, OP_DMULTU: begin
				new_hi = hi_w_q;
				new_lo = lo_w_q;
			end
			OP_DIV, OP_DIVU: begin
				if (dz_q) begin
					new_hi = sx32(a_q);
					new_lo = (sgn_div && a_q[DATA_W-1]) ? ONE : ALL_ONES;
				end else begin
					new_hi = sx32(hi_w_q);
					new_lo = sx32(lo_w_q);
				end
			end
			OP_DDIV, OP_DDIVU: begin
				if (dz_q) begin
					new_hi = a_q;
					new_lo = (sgn_div && a_q[DATA_W-1]) ? ONE : ALL_ONES;
				end else begin
					new_hi = hi_w_q;
					new_lo = lo_w_q;
				end
			end
			OP_MFHI: new_rd = hi_q;
			OP_MFLO: new_rd = lo_q;
			OP_MTHI: new_hi = a_q;
			OP_MTLO: new_lo = a_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		accept    = 1'b0;
		commit    = 1'b0;
		req.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				accept    = req.valid;
				if (req.valid) begin
					case (req.req_type) inside
						OP_MULT, OP_MULTU, OP_DIV, OP_DIVU,
						OP_DMULT, OP_DMULTU, OP_DDIV, OP_DDIVU: state_d = ST_PREP;
						default: state_d = ST_FINISH;
					endcase
				end
			end
			ST_PREP: begin
				// a zero divisor needs no iterations
				if (is_div && b_q == '0) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					state_d = ST_FIX_A;
				end
			end
			ST_FIX_A: state_d = ST_FIX_B;
			ST_FIX_B: state_d = ST_FINISH;
			ST_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Working datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q <= req.req_type;
					a_q  <= a_fmt;
					b_q  <= b_fmt;
					dz_q <= 1'b0;
				end
			end
			ST_PREP: begin
				hi_w_q <= '0;
				cnt_q  <= '0;
				if (is_div) begin
					lo_w_q  <= (sgn_div && a_q[DATA_W-1]) ? neg(a_q) : a_q;
					b_q     <= (sgn_div && b_q[DATA_W-1]) ? neg(b_q) : b_q;
					neg_q_q <= sgn_div && (a_q[DATA_W-1] ^ b_q[DATA_W-1]);
					neg_r_q <= sgn_div && a_q[DATA_W-1];
					dz_q    <= (b_q == '0);
				end else begin
					lo_w_q  <= a_q;
					neg_q_q <= 1'b0;
					neg_r_q <= 1'b0;
				end
			end
			ST_RUN: begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (is_mul) begin
					// add multiplicand on the low bit, shift the pair right
					hi_w_q <= mul_sum[DATA_W:1];
					lo_w_q <= {mul_sum[0], lo_w_q[DATA_W-1:1]};
				end else if (!div_d[DATA_W]) begin
					hi_w_q <= div_d[DATA_W-1:0];
					lo_w_q <= {lo_w_q[DATA_W-2:0], 1'b1};
				end else begin
					hi_w_q <= div_t[DATA_W-1:0];
					lo_w_q <= {lo_w_q[DATA_W-2:0], 1'b0};
				end
			end
			ST_FIX_A: begin
				if (op_q == OP_DMULT) begin
					if (a_q[DATA_W-1]) begin
						hi_w_q <= hi_w_q - b_q;
					end
				end else if (is_div) begin
					if (neg_q_q) begin
						lo_w_q <= neg(lo_w_q);
					end
					if (neg_r_q) begin
						hi_w_q <= neg(hi_w_q);
					end
				end
			end
			ST_FIX_B: begin
				if (op_q == OP_DMULT && b_q[DATA_W-1]) begin
					hi_w_q <= hi_w_q - a_q;
				end
			end
			default: ;
		endcase
	end

	// Architectural HI/LO and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q        <= '0;
			lo_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				hi_q        <= new_hi;
				lo_q        <= new_lo;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rd_q <= new_rd;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = rd_q;
	assign rsp.hi_value   = hi_q;
	assign rsp.lo_value   = lo_q;

	`MDU_ASSERT_NXT(a_run_len, state_q == ST_RUN && cnt_q == CNT_W'(DATA_W - 1), state_q == ST_FIX_A, "iteration did not end after the last bit")
	`MDU_ASSERT_NXT(a_hilo_hold, !commit, $stable(hi_q) && $stable(lo_q), "HI/LO changed without a commit")
	`MDU_ASSERT_IMP(a_commit_free, commit, !out_valid_q || rsp.ready, "result overwritten before transfer")
	`MDU_ASSERT_NXT(a_accept_busy, req.valid && req.ready, state_q != ST_IDLE, "request transfer left the unit idle")

endmodule

// File: bench/multiply_divide_unit_hi_lo_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiply_divide_unit_hi_lo_top_tb
// Self-checking bench for the HI/LO multiply/divide unit. A directed table
// covers register moves, spare opcodes, divide-by-zero and overflow corners.
// Random requests then run under three sender/receiver backpressure mixes.
// Every result transfer is checked against the table's expected values or an in-bench HI/LO model.
// ----------------------------------------------------------------------------

module multiply_divide_unit_hi_lo_top_tb;
	import mdu_pkg::*;

	localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 4'd12;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 4'd15;
	localparam int RANDOM_PER_PHASE = 234;
	localparam int QUIET_LIMIT      = 1000;
	localparam int DRAIN_CYCLES     = 100;

	typedef struct packed {
		logic [DATA_W-1:0] read_value;
		logic [DATA_W-1:0] hi_value;
		logic [DATA_W-1:0] lo_value;
	} hilo_result_t;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] rs;
		logic [DATA_W-1:0] rt;
		bit                known;
		hilo_result_t      known_res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	mdu_req_if req_ch ();
	mdu_rsp_if rsp_ch ();

	multiply_divide_unit_hi_lo_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// HI/LO model state and the results it predicts
	logic [DATA_W-1:0] model_hi;
	logic [DATA_W-1:0] model_lo;
	hilo_result_t      pending_results[$];
	stim_row_t         directed_rows[$];

	int unsigned req_idle_pct;
	int unsigned rsp_idle_pct;
	int unsigned requests_sent;
	int unsigned results_checked = 0;
	int unsigned div_by_zero_sent;
	int unsigned error_count = 0;

	function automatic logic [DATA_W-1:0] widen_word(input logic [DATA_W-1:0] v);
		return {{HALF_W{v[HALF_W-1]}}, v[HALF_W-1:0]};
	endfunction

	// truncating signed divide, divisor nonzero
	function automatic void signed_divide(input logic [DATA_W-1:0] a, b,
		output logic [DATA_W-1:0] quo, rem);
		logic [DATA_W-1:0] mag_a;
		logic [DATA_W-1:0] mag_b;
		mag_a = a[DATA_W-1] ? -a : a;
		mag_b = b[DATA_W-1] ? -b : b;
		quo = mag_a / mag_b;
		rem = mag_a % mag_b;
		if (a[DATA_W-1] != b[DATA_W-1]) begin
			quo = -quo;
		end
		if (a[DATA_W-1]) begin
			rem = -rem;
		end
	endfunction

	function automatic hilo_result_t apply_request(input logic [OP_W-1:0] op,
		input logic [DATA_W-1:0] rs, rt);
		logic [2*DATA_W-1:0] prod;
		logic [DATA_W-1:0]   a;
		logic [DATA_W-1:0]   b;
		logic [DATA_W-1:0]   quo;
		logic [DATA_W-1:0]   rem;
		hilo_result_t        res;
		res.read_value = '0;
		case (op)
			OP_MULT, OP_MULTU: begin
				a = (op == OP_MULT) ? widen_word(rs) : {{HALF_W{1'b0}}, rs[HALF_W-1:0]};
				b = (op == OP_MULT) ? widen_word(rt) : {{HALF_W{1'b0}}, rt[HALF_W-1:0]};
				quo = a * b;
				model_lo = widen_word(quo);
				model_hi = widen_word(quo >> HALF_W);
			end
			OP_DIV: begin
				a = widen_word(rs);
				b = widen_word(rt);
				if (b == '0) begin
					model_hi = a;
					model_lo = a[DATA_W-1] ? ONE : ALL_ONES;
				end else begin
					signed_divide(a, b, quo, rem);
					model_lo = widen_word(quo);
					model_hi = widen_word(rem);
				end
			end
			OP_DIVU: begin
				a = {{HALF_W{1'b0}}, rs[HALF_W-1:0]};
				b = {{HALF_W{1'b0}}, rt[HALF_W-1:0]};
				if (b == '0) begin
					model_lo = ALL_ONES;
					model_hi = widen_word(a);
				end else begin
					model_lo = widen_word(a / b);
					model_hi = widen_word(a % b);
				end
			end
			OP_DMULT, OP_DMULTU: begin
				if (op == OP_DMULT) begin
					prod = {{DATA_W{rs[DATA_W-1]}}, rs} * {{DATA_W{rt[DATA_W-1]}}, rt};
				end else begin
					prod = {{DATA_W{1'b0}}, rs} * {{DATA_W{1'b0}}, rt};
				end
				model_hi = prod[2*DATA_W-1:DATA_W];
				model_lo = prod[DATA_W-1:0];
			end
			OP_DDIV: begin
				if (rs == MOST_NEG && rt == ALL_ONES) begin
					model_lo = rs;
					model_hi = '0;
				end else if (rt == '0) begin
					model_hi = rs;
					model_lo = rs[DATA_W-1] ? ONE : ALL_ONES;
				end else begin
					signed_divide(rs, rt, quo, rem);
					model_lo = quo;
					model_hi = rem;
				end
			end
			OP_DDIVU: begin
				if (rt == '0) begin
					model_lo = ALL_ONES;
					model_hi = rs;
				end else begin
					model_lo = rs / rt;
					model_hi = rs % rt;
				end
			end
			OP_MFHI: res.read_value = model_hi;
			OP_MFLO: res.read_value = model_lo;
			OP_MTHI: model_hi = rs;
			OP_MTLO: model_lo = rs;
			default: ;
		endcase
		res.hi_value = model_hi;
		res.lo_value = model_lo;
		return res;
	endfunction

	function automatic logic [DATA_W-1:0] pick_operand();
		case ($urandom_range(9))
			0: return '0;
			1: return ALL_ONES;
			2: return MOST_NEG;
			3: return DATA_W'($urandom_range(9));
			4: return -DATA_W'($urandom_range(9));
			5: return {$urandom, 32'h0000_0000};
			6: return {$urandom, 32'h8000_0000};
			7: return {$urandom, $urandom} >> $urandom_range(DATA_W-1);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic known_row(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] rs, rt,
		input logic [DATA_W-1:0] rd, hi, lo);
		stim_row_t row;
		row.op = op;
		row.rs = rs;
		row.rt = rt;
		row.known = 1'b1;
		row.known_res = '{read_value: rd, hi_value: hi, lo_value: lo};
		directed_rows.push_back(row);
	endtask

	task automatic open_row(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] rs, rt);
		stim_row_t row;
		row.op = op;
		row.rs = rs;
		row.rt = rt;
		row.known = 1'b0;
		row.known_res = '0;
		directed_rows.push_back(row);
	endtask

	// hold the request until transfer, then record its expected result
	task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] rs, rt,
		input bit known, input hilo_result_t known_res);
		hilo_result_t predicted;
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= op;
		req_ch.rs_value <= rs;
		req_ch.rt_value <= rt;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		predicted = apply_request(op, rs, rt);
		pending_results.push_back(known ? known_res : predicted);
		requests_sent++;
		if ((op == OP_DIV && rt[HALF_W-1:0] == '0) || (op == OP_DIVU && rt[HALF_W-1:0] == '0)
			|| ((op == OP_DDIV || op == OP_DDIVU) && rt == '0)) begin
			div_by_zero_sent++;
		end
	endtask

	task automatic sender_gap();
		while ($urandom_range(99) < req_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_all_results();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic random_phase(input int unsigned send_idle, recv_idle);
		logic [OP_W-1:0] op;
		req_idle_pct = send_idle;
		rsp_idle_pct = recv_idle;
		repeat (RANDOM_PER_PHASE) begin
			if ($urandom_range(19) == 0) begin
				op = OP_SPARE_FIRST + OP_W'($urandom_range(3));
			end else begin
				op = OP_W'($urandom_range(int'(OP_MTLO)));
			end
			send_request(op, pick_operand(), pick_operand(), 1'b0, '0);
			sender_gap();
		end
		wait_all_results();
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
		end
	end

	function automatic void compare_field(input string name,
		input logic [DATA_W-1:0] want, got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		hilo_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h %h %h", $time,
					rsp_ch.read_value, rsp_ch.hi_value, rsp_ch.lo_value);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("read_value", want.read_value, rsp_ch.read_value);
				compare_field("hi_value", want.hi_value, rsp_ch.hi_value);
				compare_field("lo_value", want.lo_value, rsp_ch.lo_value);
				results_checked++;
			end
		end
	end

	// end the run if nothing transfers for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
			QUIET_LIMIT, pending_results.size());
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		stim_row_t row;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = '0;
		req_ch.rs_value = '0;
		req_ch.rt_value = '0;
		model_hi        = '0;
		model_lo        = '0;
		requests_sent   = 0;
		div_by_zero_sent = 0;
		req_idle_pct    = 17;
		rsp_idle_pct    = 80;

		//        op              rs                     rt                     read      hi                      lo
		known_row(OP_MFHI,        '0,                    '0,                    '0,       '0,                     '0);
		known_row(OP_MFLO,        '0,                    '0,                    '0,       '0,                     '0);
		known_row(OP_MTHI,        ALL_ONES,              '0,                    '0,       ALL_ONES,               '0);
		known_row(OP_MTLO,        MOST_NEG,              '0,                    '0,       ALL_ONES,               MOST_NEG);
		known_row(OP_MFHI,        '0,                    '0,                    ALL_ONES, ALL_ONES,               MOST_NEG);
		known_row(OP_MFLO,        '0,                    '0,                    MOST_NEG, ALL_ONES,               MOST_NEG);
		known_row(OP_SPARE_FIRST, 64'h0123_4567_89AB_CDEF, 64'h0123_4567_89AB_CDEF, '0,   ALL_ONES,               MOST_NEG);
		known_row(OP_SPARE_LAST,  ALL_ONES,              ALL_ONES,              '0,       ALL_ONES,               MOST_NEG);
		known_row(OP_DIV,         64'hFFFF_0000_0000_0005, 64'h1234_5678_0000_0000, '0,   64'h5,                  ALL_ONES);
		known_row(OP_DIV,         64'h1234_5678_8000_0000, '0,                  '0,       64'hFFFF_FFFF_8000_0000, ONE);
		known_row(OP_DIVU,        64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_0000_0000, '0,   64'hFFFF_FFFF_FFFF_FFFE, ALL_ONES);
		known_row(OP_DDIV,        MOST_NEG,              ALL_ONES,              '0,       '0,                     MOST_NEG);
		known_row(OP_DDIV,        64'h7,                 '0,                    '0,       64'h7,                  ALL_ONES);
		known_row(OP_DDIV,        MOST_NEG,              '0,                    '0,       MOST_NEG,               ONE);
		known_row(OP_DDIVU,       ALL_ONES,              '0,                    '0,       ALL_ONES,               ALL_ONES);
		known_row(OP_DIV,         64'h0000_0000_8000_0000, 64'h0000_0000_FFFF_FFFF, '0,   '0,                     64'hFFFF_FFFF_8000_0000);
		known_row(OP_MULT,        ALL_ONES,              ALL_ONES,              '0,       '0,                     ONE);
		known_row(OP_MULTU,       ALL_ONES,              ALL_ONES,              '0,       64'hFFFF_FFFF_FFFF_FFFE, ONE);
		known_row(OP_DMULT,       MOST_NEG,              MOST_NEG,              '0,       64'h4000_0000_0000_0000, '0);
		known_row(OP_DMULTU,      ALL_ONES,              ALL_ONES,              '0,       64'hFFFF_FFFF_FFFF_FFFE, ONE);
		known_row(OP_DMULT,       ALL_ONES,              MOST_NEG,              '0,       '0,                     MOST_NEG);
		open_row(OP_DDIVU,        ALL_ONES,              64'h3);
		open_row(OP_DDIV,         64'hFEDC_BA98_7654_3210, 64'h0000_0000_0001_2345);
		open_row(OP_DIVU,         64'h0000_0000_FFFF_FFFF, 64'h0000_0000_0000_0007);
		open_row(OP_MULT,         64'h0000_0000_7FFF_FFFF, 64'hFFFF_FFFF_8000_0000);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_request(row.op, row.rs, row.rt, row.known, row.known_res);
			sender_gap();
		end
		wait_all_results();

		random_phase(17, 80);
		random_phase(80, 17);
		random_phase(0, 0);

		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests (%0d directed, %0d divides by zero) under three stall mixes.",
			requests_sent, directed_rows.size(), div_by_zero_sent);
		$display("Checked %0d results, %0d still outstanding, %0d mismatches.",
			results_checked, pending_results.size(), error_count);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
